// ===== hw/rtl/diagnostic_event_debouncer_macros.svh =====
// Assertion macros shared by the diagnostic event debouncer RTL.
`ifndef DIAGNOSTIC_EVENT_DEBOUNCER_MACROS_SVH
`define DIAGNOSTIC_EVENT_DEBOUNCER_MACROS_SVH

`ifndef SYNTH

// The condition must hold at every clock edge outside reset.
`define DED_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define DED_ASSERT_ALWAYS(lbl, cond, msg)
`define DED_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/ded_pkg.sv =====
// Package with the types and constants of the diagnostic event debouncer.
`timescale 1ns / 1ps
`default_nettype none

package ded_pkg;

    localparam int EVENT_COUNT = 4;
    localparam int EV_W        = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
    localparam int LIMIT_COUNT = 4;

    // Commands.
    localparam logic [2:0] CMD_REPORT      = 3'd0;
    localparam logic [2:0] CMD_CLEAR       = 3'd1;
    localparam logic [2:0] CMD_READ_STATUS = 3'd2;
    localparam logic [2:0] CMD_READ_FRAME  = 3'd3;
    localparam logic [2:0] CMD_LOAD_SOURCE = 3'd4;
    localparam logic [2:0] CMD_MAIN_TICK   = 3'd5;

    // Report kinds.
    localparam logic [1:0] KIND_PREFAILED = 2'd0;
    localparam logic [1:0] KIND_PREPASSED = 2'd1;
    localparam logic [1:0] KIND_FAILED    = 2'd2;
    localparam logic [1:0] KIND_PASSED    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FAIL_TORQUE      = 3'd0;
    localparam logic [2:0] CFG_FAIL_SPEED       = 3'd1;
    localparam logic [2:0] CFG_FAIL_OVERCURRENT = 3'd2;
    localparam logic [2:0] CFG_FAIL_LINK        = 3'd3;
    localparam logic [2:0] CFG_PASS_TORQUE      = 3'd4;
    localparam logic [2:0] CFG_PASS_SPEED       = 3'd5;
    localparam logic [2:0] CFG_PASS_OVERCURRENT = 3'd6;
    localparam logic [2:0] CFG_PASS_LINK        = 3'd7;

    // Status byte bits.
    localparam logic [7:0] ST_TF     = 8'h01;
    localparam logic [7:0] ST_TFTOC  = 8'h02;
    localparam logic [7:0] ST_PDTC   = 8'h04;
    localparam logic [7:0] ST_CDTC   = 8'h08;
    localparam logic [7:0] ST_TNCSLC = 8'h10;
    localparam logic [7:0] ST_TFSLC  = 8'h20;
    localparam logic [7:0] ST_TNCTOC = 8'h40;
    localparam logic [7:0] ST_RESET  = 8'h50;
    localparam int         CDTC_BIT  = 3;

    // Limit reset values.
    localparam logic [6:0] FAIL_RESET_TORQUE      = 7'd5;
    localparam logic [6:0] FAIL_RESET_SPEED       = 7'd5;
    localparam logic [6:0] FAIL_RESET_OVERCURRENT = 7'd3;
    localparam logic [6:0] FAIL_RESET_LINK        = 7'd10;
    localparam logic signed [7:0] PASS_RESET_TORQUE      = -8'sd5;
    localparam logic signed [7:0] PASS_RESET_SPEED       = -8'sd5;
    localparam logic signed [7:0] PASS_RESET_OVERCURRENT = -8'sd3;
    localparam logic signed [7:0] PASS_RESET_LINK        = -8'sd10;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  event_index;
        logic [1:0]  report_kind;
        logic [15:0] torque_value;
        logic [15:0] speed_value;
        logic [15:0] current_value;
        logic [15:0] angle_value;
    } ded_in_t;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  status_out;
        logic [15:0] frame_torque;
        logic [15:0] frame_speed;
        logic [15:0] frame_current;
        logic [15:0] frame_angle;
        logic [31:0] writes_total;
    } ded_out_t;

    typedef struct packed {
        logic [15:0] torque;
        logic [15:0] speed;
        logic [15:0] current;
        logic [15:0] angle;
    } ded_frame_t;

    typedef struct packed {
        logic signed [7:0] count;
        logic [7:0]        status;
        ded_frame_t        frame;
    } ded_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ded_ifs.sv =====
// Valid/ready channel interfaces for requests and results of the debouncer.
`timescale 1ns / 1ps
`default_nettype none

interface ded_in_if;
    import ded_pkg::*;

    logic    valid;
    logic    ready;
    ded_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ded_out_if;
    import ded_pkg::*;

    logic     valid;
    logic     ready;
    ded_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/diagnostic_event_debouncer.sv =====
// Diagnostic event debouncer: per-event counters, status bytes and freeze frames.
// Result: the request is registered on accept and the result is registered when it completes.
// Requests: a new request is taken only while idle, after the last one has completed,
// and the event memory is read on accept, before each read-modify-write.
// Reset: limits return to their defaults, event entries read as cleared until
// written (valid bits), stored marks and the write total clear; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "diagnostic_event_debouncer_macros.svh"

module diagnostic_event_debouncer (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire  [2:0]       cfg_index,
    input  wire  [7:0]       cfg_data,
    ded_in_if.sink           request,
    ded_out_if.source        result
);
    import ded_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    ded_in_t                  req_reg;
    ded_entry_t               mem [EVENT_COUNT];
    ded_entry_t               rd_data_reg;
    logic                     entry_ok_reg;
    logic [EVENT_COUNT-1:0]   valid_reg, valid_next;
    logic [EVENT_COUNT-1:0]   stored_reg, stored_next;
    logic [EVENT_COUNT-1:0]   cdtc_reg, cdtc_next;
    logic [6:0]               fail_limit_reg [LIMIT_COUNT];
    logic signed [7:0]        pass_limit_reg [LIMIT_COUNT];
    ded_frame_t               source_reg, source_next;
    logic [31:0]              total_reg, total_next;
    logic                     result_valid_reg;
    ded_out_t                 result_data_reg, result_next;

    logic                     in_fire;
    logic                     exec_go;
    logic                     ev_ok;
    logic [EV_W-1:0]          ev;
    logic [1:0]               lim_sel;
    ded_entry_t               entry, entry_new;
    logic                     wr_en;
    logic signed [8:0]        old9, fl9, pl9, nw9, step9;
    logic                     fail_x, pass_x;
    logic [2:0]               tick_adds;

    assign in_fire       = request.valid && request.ready;
    assign request.ready = (state_reg == ST_IDLE);
    assign exec_go       = (state_reg == ST_EXEC) && (!result_valid_reg || result.ready);
    assign result.valid  = result_valid_reg;
    assign result.data   = result_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_limit_reg[0] <= FAIL_RESET_TORQUE;
            fail_limit_reg[1] <= FAIL_RESET_SPEED;
            fail_limit_reg[2] <= FAIL_RESET_OVERCURRENT;
            fail_limit_reg[3] <= FAIL_RESET_LINK;
            pass_limit_reg[0] <= PASS_RESET_TORQUE;
            pass_limit_reg[1] <= PASS_RESET_SPEED;
            pass_limit_reg[2] <= PASS_RESET_OVERCURRENT;
            pass_limit_reg[3] <= PASS_RESET_LINK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAIL_TORQUE:      fail_limit_reg[0] <= cfg_data[6:0];
                CFG_FAIL_SPEED:       fail_limit_reg[1] <= cfg_data[6:0];
                CFG_FAIL_OVERCURRENT: fail_limit_reg[2] <= cfg_data[6:0];
                CFG_FAIL_LINK:        fail_limit_reg[3] <= cfg_data[6:0];
                CFG_PASS_TORQUE:      pass_limit_reg[0] <= cfg_data;
                CFG_PASS_SPEED:       pass_limit_reg[1] <= cfg_data;
                CFG_PASS_OVERCURRENT: pass_limit_reg[2] <= cfg_data;
                CFG_PASS_LINK:        pass_limit_reg[3] <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Event memory: read on accept, written back when a report or clear request completes.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_data_reg <= mem[request.data.event_index[EV_W-1:0]];
            req_reg     <= request.data;
        end
        if (wr_en)
        begin
            mem[ev] <= entry_new;
        end
        if (exec_go)
        begin
            result_data_reg <= result_next;
        end
    end

    assign ev      = req_reg.event_index[EV_W-1:0];
    assign lim_sel = req_reg.event_index[1:0];
    assign ev_ok   = ({1'b0, req_reg.event_index} < 4'(EVENT_COUNT));

    // An entry never written since reset reads as a cleared event.
    always_comb
    begin
        if (entry_ok_reg)
        begin
            entry = rd_data_reg;
        end
        else
        begin
            entry        = '0;
            entry.status = ST_RESET;
        end
    end

    // Debounce counter step and limit crossings.
    always_comb
    begin
        old9 = 9'(entry.count);
        fl9  = $signed({2'b00, fail_limit_reg[lim_sel]});
        pl9  = 9'(pass_limit_reg[lim_sel]);
        nw9  = old9;
        step9 = old9;
        case (req_reg.report_kind)
            KIND_PREFAILED:
            begin
                step9 = old9 + 9'sd1;
                nw9   = (step9 > fl9) ? fl9 : step9;
            end
            KIND_PREPASSED:
            begin
                step9 = old9 - 9'sd1;
                nw9   = (step9 < pl9) ? pl9 : step9;
            end
            KIND_FAILED: nw9 = fl9;
            KIND_PASSED: nw9 = pl9;
            default:     nw9 = old9;
        endcase
        fail_x = (old9 < fl9) && (nw9 >= fl9);
        pass_x = !fail_x && (old9 > pl9) && (nw9 <= pl9);
    end

    always_comb
    begin
        entry_new   = entry;
        wr_en       = 1'b0;
        valid_next  = valid_reg;
        stored_next = stored_reg;
        cdtc_next   = cdtc_reg;
        source_next = source_reg;
        total_next  = total_reg;
        tick_adds   = '0;
        result_next = '0;

        case (req_reg.command)
            CMD_REPORT:
            begin
                if (ev_ok)
                begin
                    entry_new.count = nw9[7:0];
                    if (fail_x)
                    begin
                        entry_new.status = (entry.status | ST_TF | ST_TFTOC | ST_CDTC | ST_TFSLC)
                                           & ~(ST_TNCTOC | ST_TNCSLC);
                        entry_new.frame  = source_reg;
                        stored_next[ev]  = 1'b0;
                    end
                    else if (pass_x)
                    begin
                        entry_new.status = entry.status
                                           & ~(ST_TF | ST_PDTC | ST_TNCTOC | ST_TNCSLC);
                    end
                    wr_en                = exec_go;
                    result_next.accepted = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                if (ev_ok)
                begin
                    entry_new.status     = ST_RESET;
                    entry_new.count      = '0;
                    stored_next[ev]      = 1'b0;
                    wr_en                = exec_go;
                    result_next.accepted = 1'b1;
                end
            end
            CMD_READ_STATUS, CMD_READ_FRAME:
            begin
                result_next.accepted = ev_ok;
            end
            CMD_LOAD_SOURCE:
            begin
                source_next.torque   = req_reg.torque_value;
                source_next.speed    = req_reg.speed_value;
                source_next.current  = req_reg.current_value;
                source_next.angle    = req_reg.angle_value;
                result_next.accepted = 1'b1;
            end
            CMD_MAIN_TICK:
            begin
                for (int i = 0; i < EVENT_COUNT; i++)
                begin
                    if (cdtc_reg[i] && !stored_reg[i])
                    begin
                        tick_adds = tick_adds + 3'd1;
                    end
                end
                stored_next          = stored_reg | cdtc_reg;
                total_next           = total_reg + 32'(tick_adds);
                result_next.accepted = 1'b1;
            end
            default: ;
        endcase

        if (wr_en)
        begin
            valid_next[ev] = 1'b1;
            cdtc_next[ev]  = entry_new.status[CDTC_BIT];
        end

        if (ev_ok)
        begin
            result_next.status_out    = entry_new.status;
            result_next.frame_torque  = entry_new.frame.torque;
            result_next.frame_speed   = entry_new.frame.speed;
            result_next.frame_current = entry_new.frame.current;
            result_next.frame_angle   = entry_new.frame.angle;
        end
        result_next.writes_total = total_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_EXEC;
            ST_EXEC: if (exec_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            entry_ok_reg     <= 1'b0;
            valid_reg        <= '0;
            stored_reg       <= '0;
            cdtc_reg         <= '0;
            source_reg       <= '0;
            total_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                entry_ok_reg <= valid_reg[request.data.event_index[EV_W-1:0]];
            end
            if (exec_go)
            begin
                valid_reg        <= valid_next;
                stored_reg       <= stored_next;
                cdtc_reg         <= cdtc_next;
                source_reg       <= source_next;
                total_reg        <= total_next;
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // An event is only ever marked stored while it is confirmed.
    `DED_ASSERT_ALWAYS(a_stored_needs_cdtc, (stored_reg & ~cdtc_reg) == '0, "stored mark without CDTC")
    // Every accepted request goes on to its read-modify-write cycle.
    `DED_ASSERT_NEXT(a_accept_to_exec, in_fire, state_reg == ST_EXEC, "accepted request not executed")
    // The write total moves only when a main tick completes.
    `DED_ASSERT_NEXT(a_total_only_on_tick, !(exec_go && req_reg.command == CMD_MAIN_TICK), $stable(total_reg), "write total changed without a tick")
    // A completing request always leaves a result behind.
    `DED_ASSERT_NEXT(a_exec_gives_result, exec_go, result_valid_reg, "completed request gave no result")

endmodule

`default_nettype wire
